>>> hdl/u2u8_pkg.sv
// ----------------------------------------------------------------------------
// u2u8_pkg
// Shared types and constants for the UTF-16 to UTF-8 transcoder.
// ----------------------------------------------------------------------------
package u2u8_pkg;

    // Result kinds carried on the output tuser.
    localparam logic [1:0] KIND_DATA   = 2'd0;
    localparam logic [1:0] KIND_OK     = 2'd1;
    localparam logic [1:0] KIND_FAILED = 2'd2;

    // Surrogate ranges, tested on the upper six bits of a code unit.
    localparam logic [5:0] HIGH_SURR_TAG = 6'b110110;   // 0xD800 .. 0xDBFF
    localparam logic [5:0] LOW_SURR_TAG  = 6'b110111;   // 0xDC00 .. 0xDFFF

    // Encoding limits and lead/continuation patterns.
    localparam logic [15:0] ONE_BYTE_MAX = 16'h007f;
    localparam logic [15:0] TWO_BYTE_MAX = 16'h07ff;
    localparam logic [7:0]  LEAD2        = 8'hc0;
    localparam logic [7:0]  LEAD3        = 8'he0;
    localparam logic [7:0]  LEAD4        = 8'hf0;
    localparam logic [7:0]  CONT         = 8'h80;

    // Adds 0x10000 to a supplementary code point, seen from bit 10 upward.
    localparam logic [10:0] SUPP_BASE_HI = 11'h040;

    localparam int unsigned FIFO_DEPTH = 4;

    // One classified input item: up to four data bytes, then an optional status.
    typedef struct packed {
        logic [3:0][7:0] bytes;      // bytes[0] goes out first
        logic [2:0]      nbytes;     // 0 to 4
        logic            has_status;
        logic            failed;
    } job_t;

endpackage

>>> hdl/u2u8_front.sv
// ----------------------------------------------------------------------------
// u2u8_front
// Accepts code units, tracks surrogate and failure state, and builds one job
// per input item that causes any result.
// ----------------------------------------------------------------------------
module u2u8_front
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [15:0]       s_tdata,   // code_unit
    input  logic              s_tlast,   // text_last
    input  logic              queue_full,
    output logic              push,
    output u2u8_pkg::job_t    job
);

    logic        pending_high_reg, pending_high_next;
    logic [9:0]  high_offset_reg, high_offset_next;
    logic        text_failed_reg, text_failed_next;
    logic        accept;
    logic        is_high;
    logic        is_low;
    logic        enc_supp;
    logic        enc_bmp;
    logic [10:0] supp_hi;

    assign s_tready = !queue_full;
    assign accept   = s_tvalid && s_tready;
    assign is_high  = (s_tdata[15:10] == u2u8_pkg::HIGH_SURR_TAG);
    assign is_low   = (s_tdata[15:10] == u2u8_pkg::LOW_SURR_TAG);

    // Bits 20..10 of the supplementary code point.
    assign supp_hi  = {1'b0, high_offset_reg} + u2u8_pkg::SUPP_BASE_HI;

    always_comb
    begin
        pending_high_next = pending_high_reg;
        high_offset_next  = high_offset_reg;
        text_failed_next  = text_failed_reg;
        enc_supp          = 1'b0;
        enc_bmp           = 1'b0;
        job               = '0;

        if (!text_failed_reg)
        begin
            if (pending_high_reg)
            begin
                pending_high_next = 1'b0;
                high_offset_next  = '0;
                if (is_low)
                    enc_supp = 1'b1;
                else
                    text_failed_next = 1'b1;
            end
            else if (is_high)
            begin
                pending_high_next = 1'b1;
                high_offset_next  = s_tdata[9:0];
            end
            else if (is_low)
                text_failed_next = 1'b1;
            else
                enc_bmp = 1'b1;
        end

        if (enc_supp)
        begin
            job.nbytes   = 3'd4;
            job.bytes[0] = u2u8_pkg::LEAD4 | {5'd0, supp_hi[10:8]};
            job.bytes[1] = u2u8_pkg::CONT  | {2'd0, supp_hi[7:2]};
            job.bytes[2] = u2u8_pkg::CONT  | {2'd0, supp_hi[1:0], s_tdata[9:6]};
            job.bytes[3] = u2u8_pkg::CONT  | {2'd0, s_tdata[5:0]};
        end
        else if (enc_bmp)
        begin
            if (s_tdata <= u2u8_pkg::ONE_BYTE_MAX)
            begin
                job.nbytes   = 3'd1;
                job.bytes[0] = s_tdata[7:0];
            end
            else if (s_tdata <= u2u8_pkg::TWO_BYTE_MAX)
            begin
                job.nbytes   = 3'd2;
                job.bytes[0] = u2u8_pkg::LEAD2 | {3'd0, s_tdata[10:6]};
                job.bytes[1] = u2u8_pkg::CONT  | {2'd0, s_tdata[5:0]};
            end
            else
            begin
                job.nbytes   = 3'd3;
                job.bytes[0] = u2u8_pkg::LEAD3 | {4'd0, s_tdata[15:12]};
                job.bytes[1] = u2u8_pkg::CONT  | {2'd0, s_tdata[11:6]};
                job.bytes[2] = u2u8_pkg::CONT  | {2'd0, s_tdata[5:0]};
            end
        end

        if (s_tlast)
        begin
            // A text that ends on a pending high surrogate has failed.
            job.has_status    = 1'b1;
            job.failed        = text_failed_next || pending_high_next;
            pending_high_next = 1'b0;
            high_offset_next  = '0;
            text_failed_next  = 1'b0;
        end
    end

    assign push = accept && ((job.nbytes != 3'd0) || job.has_status);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_high_reg <= 1'b0;
            high_offset_reg  <= '0;
            text_failed_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pending_high_reg <= pending_high_next;
            high_offset_reg  <= high_offset_next;
            text_failed_reg  <= text_failed_next;
        end
    end

endmodule

>>> hdl/u2u8_fifo.sv
// ----------------------------------------------------------------------------
// u2u8_fifo
// Small job queue between the front and the back; the head is read directly.
// ----------------------------------------------------------------------------
module u2u8_fifo
#(
    parameter int unsigned DEPTH = u2u8_pkg::FIFO_DEPTH
)
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  u2u8_pkg::job_t push_data,
    output logic           full,
    input  logic           pop,
    output u2u8_pkg::job_t head,
    output logic           empty
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    u2u8_pkg::job_t  mem [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [AW:0]     count_reg, count_next;

    assign full  = (count_reg == (AW+1)'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("job queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("job queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (AW+1)'(DEPTH))
        else $error("job queue count out of range");

endmodule

>>> hdl/u2u8_back.sv
// ----------------------------------------------------------------------------
// u2u8_back
// Drains the head job one result per unstalled cycle into the output register.
// ----------------------------------------------------------------------------
module u2u8_back
(
    input  logic           clk,
    input  logic           rst_n,
    input  u2u8_pkg::job_t head,
    input  logic           empty,
    output logic           pop,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata,   // out_byte
    output logic [1:0]     m_tuser,   // kind
    output logic           m_tlast    // run_last
);

    logic [2:0] idx_reg, idx_next;
    logic       m_tvalid_reg, m_tvalid_next;
    logic [7:0] m_tdata_reg, m_tdata_next;
    logic [1:0] m_tuser_reg, m_tuser_next;
    logic       m_tlast_reg, m_tlast_next;
    logic       out_free;
    logic       load;
    logic       is_byte;
    logic       last_res;
    logic [2:0] total;

    assign out_free = !m_tvalid_reg || m_tready;
    assign load     = !empty && out_free;
    assign total    = head.nbytes + {2'd0, head.has_status};
    assign is_byte  = (idx_reg < head.nbytes);
    assign last_res = ((idx_reg + 3'd1) == total);
    assign pop      = load && last_res;

    always_comb
    begin
        idx_next      = idx_reg;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (load)
        begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = last_res;
            idx_next      = last_res ? 3'd0 : idx_reg + 3'd1;
            if (is_byte)
            begin
                m_tdata_next = head.bytes[idx_reg[1:0]];
                m_tuser_next = u2u8_pkg::KIND_DATA;
            end
            else
            begin
                m_tdata_next = 8'd0;
                m_tuser_next = head.failed ? u2u8_pkg::KIND_FAILED : u2u8_pkg::KIND_OK;
            end
        end
        else if (m_tready)
            m_tvalid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            idx_reg      <= idx_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    a_status_ends_run: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_tuser_reg != u2u8_pkg::KIND_DATA)) |-> m_tlast_reg)
        else $error("status result not marked as last of its run");

    a_status_zero_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && (m_tuser_reg != u2u8_pkg::KIND_DATA)) |-> (m_tdata_reg == 8'd0))
        else $error("status result carries a nonzero byte");

    a_partial_job_held: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> !empty)
        else $error("partly drained job left the head of the queue");

endmodule

>>> hdl/utf16_to_utf8_transcoder.sv
// ----------------------------------------------------------------------------
// utf16_to_utf8_transcoder
// Converts a stream of UTF-16 code units into UTF-8 bytes with a status
// result at the end of every text.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  tdata              tuser      tlast
//  s_*      in         code_unit [15:0]   -          text_last
//  m_*      out        out_byte  [7:0]    kind [1:0] run_last
//
// The front classifies each code unit in the cycle it is accepted and queues
// one job holding up to four bytes and an optional status. The back sends one
// result per cycle while the output is not stalled. An item yields one to three
// bytes for a unit of the Basic Multilingual Plane and four for a completed
// surrogate pair, plus a status result when the unit ends a text; a unit that
// yields no byte and ends no text queues no job.
// One transfer per unstalled cycle on the single port sets the sustained rate.
// Input is taken whenever the job queue has room, also while a result is
// stalled in the output register. Reset is asynchronous and clears the
// surrogate state, the queue and the output valid.
//
module utf16_to_utf8_transcoder
#(
    parameter int unsigned FIFO_DEPTH = u2u8_pkg::FIFO_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [15:0] code_unit
    input  logic        s_tlast,   // text_last

    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic [1:0]  m_tuser,   // [1:0] kind
    output logic        m_tlast    // run_last
);

    // Job handed from the classifier into the queue, and the queue head.
    u2u8_pkg::job_t push_job;
    u2u8_pkg::job_t head_job;
    logic           push;
    logic           pop;
    logic           queue_full;
    logic           queue_empty;

    // The front holds the surrogate pairing and failure state of the text.
    u2u8_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .job        (push_job)
    );

    // A short queue lets the front keep taking units while the back drains.
    u2u8_fifo #(.DEPTH(FIFO_DEPTH)) u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_job),
        .full      (queue_full),
        .pop       (pop),
        .head      (head_job),
        .empty     (queue_empty)
    );

    // The back serializes each job into byte and status transfers.
    u2u8_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .head     (head_job),
        .empty    (queue_empty),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule
